[hw/rtl/heap_segment_allocator_assert.svh]
// Assertion macros for the heap segment allocator RTL.
`ifndef HEAP_SEGMENT_ALLOCATOR_ASSERT_SVH
`define HEAP_SEGMENT_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define HSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heap segment allocator check failed");
`define HSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heap segment allocator check failed");
`else
`define HSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// hsa_pkg
// Types and codes shared by the heap segment allocator modules.
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int NEED_W = 17;

    localparam logic [0:0] KIND_ALLOC = 1'b0;
    localparam logic [0:0] KIND_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_BAD_FREE = 3'd3;
    localparam logic [2:0] ST_NULL     = 3'd4;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_WRITE,
        OP_INSERT,
        OP_DROP
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SPLIT,
        S_MERGE_L,
        S_MERGE_R,
        S_DONE
    } t_state;

endpackage

[hw/rtl/hsa_if.sv]
// ----------------------------------------------------------------------------
// hsa_req_if / hsa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface hsa_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [15:0] request_bytes;
    logic [15:0] data_address;

    modport source (output valid, kind, request_bytes, data_address, input ready);
    modport sink   (input valid, kind, request_bytes, data_address, output ready);
endinterface

interface hsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] granted_address;
    logic [15:0] granted_bytes;
    logic [0:0]  reused;

    modport source (output valid, status, granted_address, granted_bytes, reused,
                    input ready);
    modport sink   (input valid, status, granted_address, granted_bytes, reused,
                    output ready);
endinterface

[hw/rtl/hsa_cell.sv]
// ----------------------------------------------------------------------------
// hsa_cell
// One segment table entry. It loads from the sequencer or from a neighbor.
// ----------------------------------------------------------------------------
module hsa_cell
    import hsa_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IW       = 6,
    parameter int TW       = 17,
    parameter bit IS_LAST  = 1'b0
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [IW-1:0] i_idx,
    input  logic [TW-1:0] i_wr_off,
    input  logic [TW-1:0] i_wr_size,
    input  logic          i_wr_free,
    input  logic [TW-1:0] i_left_off,
    input  logic [TW-1:0] i_left_size,
    input  logic          i_left_free,
    input  logic [TW-1:0] i_right_off,
    input  logic [TW-1:0] i_right_size,
    input  logic          i_right_free,
    output logic [TW-1:0] o_off,
    output logic [TW-1:0] o_size,
    output logic          o_free
);

    localparam logic [IW-1:0] MyIdx = IW'(CELL_IDX);

    logic [TW-1:0] r_off;
    logic [TW-1:0] r_size;
    logic          r_free;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ROTATE: begin
                r_off  <= i_right_off;
                r_size <= i_right_size;
                r_free <= i_right_free;
            end
            OP_WRITE: begin
                if (i_idx == MyIdx) begin
                    r_off  <= i_wr_off;
                    r_size <= i_wr_size;
                    r_free <= i_wr_free;
                end
            end
            OP_INSERT: begin
                if (i_idx == MyIdx) begin
                    r_off  <= i_wr_off;
                    r_size <= i_wr_size;
                    r_free <= i_wr_free;
                end else if (MyIdx > i_idx) begin
                    r_off  <= i_left_off;
                    r_size <= i_left_size;
                    r_free <= i_left_free;
                end
            end
            OP_DROP: begin
                // The last cell keeps its content; it lies past the table end.
                if (!IS_LAST && MyIdx >= i_idx) begin
                    r_off  <= i_right_off;
                    r_size <= i_right_size;
                    r_free <= i_right_free;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_off  = r_off;
    assign o_size = r_size;
    assign o_free = r_free;

endmodule

[hw/rtl/heap_segment_allocator.sv]
// ----------------------------------------------------------------------------
// heap_segment_allocator
// Address-ordered heap segment table with first, best, worst and next fit.
// ----------------------------------------------------------------------------
// The segment table is a ring of MAX_SEGMENTS cells. Every allocate or free
// transaction with a nonzero size or address rotates the ring once around,
// one entry per cycle past the head cell, to search it, and then applies an
// in-place write, an insert for a split, or drops for merges, where each cell
// moves data to its neighbor. A zero size or null free skips the search. One
// transaction is handled at a time; the response sits in an output register
// so the next request is taken while it waits.
module heap_segment_allocator
    import hsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    hsa_req_if.sink     i_req,
    hsa_rsp_if.source   o_rsp
);

`include "heap_segment_allocator_assert.svh"

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = $clog2(HEAP_BYTES + 1);
    localparam int SW = ((TW > NEED_W) ? TW : NEED_W) + 2;
    localparam logic [SW-1:0] HdrS  = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] HeapS = SW'(HEAP_BYTES);
    localparam logic [CW-1:0] MaxC  = CW'(MAX_SEGMENTS);
    localparam logic [IW-1:0] LastK = IW'(MAX_SEGMENTS - 1);

    // Cell ring
    t_cell_op      w_op;
    logic [IW-1:0] w_idx;
    logic [TW-1:0] w_wr_off;
    logic [TW-1:0] w_wr_size;
    logic          w_wr_free;
    logic [TW-1:0] w_off  [MAX_SEGMENTS];
    logic [TW-1:0] w_size [MAX_SEGMENTS];
    logic          w_free [MAX_SEGMENTS];

    for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
        localparam int LeftJ  = (j == 0) ? 0 : j - 1;
        localparam int RightJ = (j + 1) % MAX_SEGMENTS;
        hsa_cell #(
            .CELL_IDX (j),
            .IW       (IW),
            .TW       (TW),
            .IS_LAST  (j == MAX_SEGMENTS - 1)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_idx        (w_idx),
            .i_wr_off     (w_wr_off),
            .i_wr_size    (w_wr_size),
            .i_wr_free    (w_wr_free),
            .i_left_off   (w_off[LeftJ]),
            .i_left_size  (w_size[LeftJ]),
            .i_left_free  (w_free[LeftJ]),
            .i_right_off  (w_off[RightJ]),
            .i_right_size (w_size[RightJ]),
            .i_right_free (w_free[RightJ]),
            .o_off        (w_off[j]),
            .o_size       (w_size[j]),
            .o_free       (w_free[j])
        );
    end

    // Control and request registers
    t_state              r_state, n_state;
    logic [1:0]          r_policy;
    logic [CW-1:0]       r_count;
    logic [TW-1:0]       r_top;
    logic [IW-1:0]       r_nf;
    logic [IW-1:0]       r_k;
    logic [0:0]          r_kind;
    logic [NEED_W-1:0]   r_need;
    logic [15:0]         r_addr;

    // Search results
    logic          r_pf, r_wf;
    logic [IW-1:0] r_pidx, r_widx;
    logic [TW-1:0] r_poff, r_woff, r_psize, r_wsize;
    logic          r_hf, r_hfree, r_grab;
    logic [IW-1:0] r_hit;
    logic [TW-1:0] r_hoff, r_hsize;
    logic          r_pvfree, r_nxfree;
    logic [TW-1:0] r_pvoff, r_pvsize, r_nxsize;
    logic          r_left, r_right;
    logic [IW-1:0] r_m;

    // Result of the transaction in progress
    logic [2:0]  r_status;
    logic [15:0] r_gaddr;
    logic [15:0] r_gbytes;
    logic        r_reused;

    // Output register
    logic        r_out_valid;
    logic [2:0]  r_rsp_status;
    logic [15:0] r_rsp_gaddr;
    logic [15:0] r_rsp_gbytes;
    logic        r_rsp_reused;

    logic w_accept;
    assign w_accept     = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);

    // Scan view of the head cell
    logic          w_kvalid, w_fit, w_cand, w_match;
    logic [IW-1:0] w_start;
    logic [31:0]   w_head_data;
    assign w_kvalid    = CW'(r_k) < r_count;
    assign w_fit       = w_free[0] && (SW'(w_size[0]) >= SW'(r_need));
    assign w_cand      = w_kvalid && w_fit;
    assign w_head_data = 32'(w_off[0]) + 32'(HEADER_BYTES);
    assign w_match     = w_kvalid && (w_head_data[15:0] == r_addr);
    assign w_start     = (CW'(r_nf) < r_count) ? r_nf : '0;

    // Allocation decision
    logic          w_sel;
    logic [IW-1:0] w_sidx;
    logic [TW-1:0] w_soff, w_ssize;
    logic          w_split, w_grow_ok;
    logic [SW-1:0] w_surplus, w_grow_end;
    logic [31:0]   w_gaddr_sel, w_gaddr_top;
    always_comb begin
        w_sel  = r_pf || (r_policy == POL_NEXT && r_wf);
        w_sidx = r_pf ? r_pidx : r_widx;
        w_soff = r_pf ? r_poff : r_woff;
        w_ssize = r_pf ? r_psize : r_wsize;
        w_surplus  = SW'(w_ssize) - SW'(r_need);
        w_split    = (w_surplus > HdrS) && (r_count < MaxC);
        w_grow_end = SW'(r_top) + HdrS + SW'(r_need);
        w_grow_ok  = (r_count < MaxC) && (w_grow_end <= HeapS);
        w_gaddr_sel = 32'(w_soff) + 32'(HEADER_BYTES);
        w_gaddr_top = 32'(r_top) + 32'(HEADER_BYTES);
    end

    // Free decision
    logic          w_bad, w_left;
    logic [SW-1:0] w_base, w_total;
    always_comb begin
        w_bad   = !r_hf || r_hfree;
        w_left  = (r_hit != '0) && r_pvfree;
        w_base  = w_left ? (SW'(r_pvsize) + SW'(r_hsize) + HdrS) : SW'(r_hsize);
        w_total = r_nxfree ? (w_base + SW'(r_nxsize) + HdrS) : w_base;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_req.kind == KIND_ALLOC && i_req.request_bytes == '0) ||
                        (i_req.kind == KIND_FREE && i_req.data_address == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_k == LastK) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (r_kind == KIND_ALLOC) begin
                    n_state = (w_sel && w_split) ? S_SPLIT : S_DONE;
                end else begin
                    n_state = w_bad ? S_DONE : S_MERGE_L;
                end
            end
            S_SPLIT:   n_state = S_DONE;
            S_MERGE_L: n_state = S_MERGE_R;
            S_MERGE_R: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Cell commands
    always_comb begin
        w_op      = OP_HOLD;
        w_idx     = '0;
        w_wr_off  = '0;
        w_wr_size = '0;
        w_wr_free = 1'b0;
        unique case (r_state)
            S_SCAN: w_op = OP_ROTATE;
            S_APPLY: begin
                if (r_kind == KIND_ALLOC) begin
                    if (w_sel) begin
                        w_op      = OP_WRITE;
                        w_idx     = w_sidx;
                        w_wr_off  = w_soff;
                        w_wr_size = w_split ? TW'(r_need) : w_ssize;
                    end else if (w_grow_ok) begin
                        w_op      = OP_WRITE;
                        w_idx     = r_count[IW-1:0];
                        w_wr_off  = r_top;
                        w_wr_size = TW'(r_need);
                    end
                end else if (!w_bad) begin
                    w_op      = OP_WRITE;
                    w_idx     = w_left ? (r_hit - 1'b1) : r_hit;
                    w_wr_off  = w_left ? r_pvoff : r_hoff;
                    w_wr_size = TW'(w_total);
                    w_wr_free = 1'b1;
                end
            end
            // The split uses the pick that was chosen in the apply cycle.
            S_SPLIT: begin
                w_op      = OP_INSERT;
                w_idx     = w_sidx + 1'b1;
                w_wr_off  = TW'(SW'(w_soff) + HdrS + SW'(r_need));
                w_wr_size = TW'(SW'(w_ssize) - SW'(r_need) - HdrS);
                w_wr_free = 1'b1;
            end
            S_MERGE_L: begin
                if (r_left) begin
                    w_op  = OP_DROP;
                    w_idx = r_hit;
                end
            end
            S_MERGE_R: begin
                if (r_right) begin
                    w_op  = OP_DROP;
                    w_idx = r_m + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_FIRST;
            r_count     <= '0;
            r_top       <= '0;
            r_nf        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid  <= 1'b1;
                r_rsp_status <= r_status;
                r_rsp_gaddr  <= r_gaddr;
                r_rsp_gbytes <= r_gbytes;
                r_rsp_reused <= r_reused;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= i_req.kind;
                        r_need   <= ((NEED_W'(i_req.request_bytes) - 1'b1) >> 2 << 2)
                                    + NEED_W'(4);
                        r_addr   <= i_req.data_address;
                        r_k      <= '0;
                        r_pf     <= 1'b0;
                        r_wf     <= 1'b0;
                        r_hf     <= 1'b0;
                        r_grab   <= 1'b0;
                        r_nxfree <= 1'b0;
                        r_gaddr  <= '0;
                        r_gbytes <= '0;
                        r_reused <= 1'b0;
                        r_status <= (i_req.kind == KIND_ALLOC) ? ST_ZERO : ST_NULL;
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    // Keep the entry just before the freed one once it is found.
                    if (!r_hf && !w_match) begin
                        r_pvfree <= w_free[0];
                        r_pvsize <= w_size[0];
                        r_pvoff  <= w_off[0];
                    end
                    if (r_kind == KIND_ALLOC) begin
                        unique case (r_policy)
                            POL_FIRST: begin
                                if (w_cand && !r_pf) begin
                                    r_pf <= 1'b1; r_pidx <= r_k;
                                    r_poff <= w_off[0]; r_psize <= w_size[0];
                                end
                            end
                            POL_BEST: begin
                                if (w_cand && (!r_pf || w_size[0] <= r_psize)) begin
                                    r_pf <= 1'b1; r_pidx <= r_k;
                                    r_poff <= w_off[0]; r_psize <= w_size[0];
                                end
                            end
                            POL_WORST: begin
                                if (w_cand && (!r_pf || w_size[0] >= r_psize)) begin
                                    r_pf <= 1'b1; r_pidx <= r_k;
                                    r_poff <= w_off[0]; r_psize <= w_size[0];
                                end
                            end
                            default: begin
                                if (w_cand && !r_pf && r_k >= w_start) begin
                                    r_pf <= 1'b1; r_pidx <= r_k;
                                    r_poff <= w_off[0]; r_psize <= w_size[0];
                                end
                                if (w_cand && !r_wf) begin
                                    r_wf <= 1'b1; r_widx <= r_k;
                                    r_woff <= w_off[0]; r_wsize <= w_size[0];
                                end
                            end
                        endcase
                    end else begin
                        if (w_match && !r_hf) begin
                            r_hf     <= 1'b1;
                            r_hit    <= r_k;
                            r_hoff   <= w_off[0];
                            r_hsize  <= w_size[0];
                            r_hfree  <= w_free[0];
                            r_grab   <= 1'b1;
                        end else if (r_grab) begin
                            r_grab <= 1'b0;
                            if (w_kvalid) begin
                                r_nxfree <= w_free[0];
                                r_nxsize <= w_size[0];
                            end
                        end
                    end
                end
                S_APPLY: begin
                    if (r_kind == KIND_ALLOC) begin
                        if (w_sel) begin
                            r_pidx   <= w_sidx;
                            r_nf     <= w_sidx;
                            r_status <= ST_OK;
                            r_gaddr  <= w_gaddr_sel[15:0];
                            r_gbytes <= r_need[15:0];
                            r_reused <= 1'b1;
                        end else if (w_grow_ok) begin
                            r_nf     <= r_count[IW-1:0];
                            r_count  <= r_count + 1'b1;
                            r_top    <= TW'(w_grow_end);
                            r_status <= ST_OK;
                            r_gaddr  <= w_gaddr_top[15:0];
                            r_gbytes <= r_need[15:0];
                        end else begin
                            r_status <= ST_NO_SPACE;
                        end
                    end else if (w_bad) begin
                        r_status <= ST_BAD_FREE;
                    end else begin
                        r_status <= ST_OK;
                        r_left   <= w_left;
                        r_right  <= r_nxfree;
                        r_m      <= w_left ? (r_hit - 1'b1) : r_hit;
                    end
                end
                S_SPLIT: begin
                    r_count <= r_count + 1'b1;
                end
                S_MERGE_L: begin
                    if (r_left) begin
                        r_count <= r_count - 1'b1;
                        if (r_nf >= r_hit && r_nf != '0) begin
                            r_nf <= r_nf - 1'b1;
                        end
                    end
                end
                S_MERGE_R: begin
                    if (r_right) begin
                        r_count <= r_count - 1'b1;
                        if (r_nf >= (r_m + 1'b1) && r_nf != '0) begin
                            r_nf <= r_nf - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_rsp_status;
    assign o_rsp.granted_address = r_rsp_gaddr;
    assign o_rsp.granted_bytes   = r_rsp_gbytes;
    assign o_rsp.reused          = r_rsp_reused;

    `HSA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MaxC)
    `HSA_ASSERT_IMPL(a_top_bound, i_clk, i_rst_n, 1'b1, SW'(r_top) <= HeapS)
    `HSA_ASSERT_IMPL(a_nf_in_table, i_clk, i_rst_n, 1'b1,
                     (r_count == '0) || (CW'(r_nf) < r_count))
    `HSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept,
                     r_state != S_IDLE)

endmodule

[tb/sv/heap_segment_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_segment_allocator_test
// Drives allocate and free requests through the allocator under all four fit
// policies. A scoreboard holds its own copy of the segment table, predicts
// each response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

typedef struct {
    logic [2:0]  status;
    logic [15:0] address;
    logic [15:0] bytes;
    logic        reused;
} t_grant;

class heap_scoreboard;
    localparam int unsigned SEGS   = 64;
    localparam int unsigned HEAP   = 65536;
    localparam int unsigned HEADER = 32;

    int unsigned seg_off [SEGS];
    int unsigned seg_size[SEGS];
    bit          seg_free[SEGS];
    int unsigned seg_count;
    int unsigned top;
    int unsigned roving;
    logic [1:0]  policy;
    t_grant      pending[$];
    int          errors;

    function new();
        seg_count = 0;
        top       = 0;
        roving    = 0;
        policy    = hsa_pkg::POL_FIRST;
        errors    = 0;
    endfunction

    function void set_policy(logic [1:0] p);
        policy = p;
    endfunction

    // Data address of a random used segment, or 0 if every segment is free.
    function logic [15:0] used_address();
        int unsigned live[$];
        for (int unsigned i = 0; i < seg_count; i++)
            if (!seg_free[i]) live.push_back(i);
        if (live.size() == 0) return 16'd0;
        return 16'((seg_off[live[$urandom_range(live.size() - 1)]] + HEADER) & 16'hFFFF);
    endfunction

    function logic [15:0] any_address();
        if (seg_count == 0) return 16'd0;
        return 16'((seg_off[$urandom_range(seg_count - 1)] + HEADER) & 16'hFFFF);
    endfunction

    function void drop_entry(int unsigned idx);
        for (int unsigned j = idx; j + 1 < seg_count; j++) begin
            seg_off[j]  = seg_off[j + 1];
            seg_size[j] = seg_size[j + 1];
            seg_free[j] = seg_free[j + 1];
        end
        seg_count--;
        if (roving >= idx && roving > 0) roving--;
    endfunction

    function void insert_free(int unsigned idx, int unsigned off, int unsigned size);
        for (int unsigned j = seg_count; j > idx; j--) begin
            seg_off[j]  = seg_off[j - 1];
            seg_size[j] = seg_size[j - 1];
            seg_free[j] = seg_free[j - 1];
        end
        seg_off[idx]  = off;
        seg_size[idx] = size;
        seg_free[idx] = 1'b1;
        seg_count++;
    endfunction

    function int unsigned find_fit(int unsigned need);
        int unsigned i;
        int unsigned pick;
        int unsigned start;
        pick = seg_count;
        for (int unsigned k = 0; k < seg_count; k++) begin
            if (policy == hsa_pkg::POL_NEXT) begin
                start = (roving < seg_count) ? roving : 0;
                i = start + k;
                if (i >= seg_count) i -= seg_count;
            end else begin
                i = k;
            end
            if (!seg_free[i] || seg_size[i] < need) continue;
            if (policy == hsa_pkg::POL_FIRST || policy == hsa_pkg::POL_NEXT) return i;
            // Ties go to the higher address, hence <= and >=.
            if (pick == seg_count ||
                (policy == hsa_pkg::POL_BEST  && seg_size[i] <= seg_size[pick]) ||
                (policy == hsa_pkg::POL_WORST && seg_size[i] >= seg_size[pick]))
                pick = i;
        end
        return pick;
    endfunction

    function t_grant allocate(int unsigned req);
        t_grant      g;
        int unsigned need;
        int unsigned idx;
        bit          reuse;
        g = '{hsa_pkg::ST_OK, 16'd0, 16'd0, 1'b0};
        if (req == 0) begin
            g.status = hsa_pkg::ST_ZERO;
            return g;
        end
        need  = (((req - 1) >> 2) << 2) + 4;
        idx   = find_fit(need);
        reuse = idx < seg_count;
        if (!reuse) begin
            if (seg_count >= SEGS || HEAP < top || HEAP - top < HEADER + need) begin
                g.status = hsa_pkg::ST_NO_SPACE;
                return g;
            end
            idx = seg_count;
            seg_off[idx]  = top;
            seg_size[idx] = need;
            seg_count++;
            top += HEADER + need;
        end else if (seg_size[idx] - need > HEADER && seg_count < SEGS) begin
            insert_free(idx + 1, seg_off[idx] + HEADER + need, seg_size[idx] - need - HEADER);
            seg_size[idx] = need;
        end
        seg_free[idx] = 1'b0;
        roving        = idx;
        g.address = 16'((seg_off[idx] + HEADER) & 16'hFFFF);
        g.bytes   = 16'(need & 16'hFFFF);
        g.reused  = reuse;
        return g;
    endfunction

    function t_grant release_segment(logic [15:0] addr);
        t_grant      g;
        int unsigned hit;
        int unsigned i;
        g   = '{hsa_pkg::ST_OK, 16'd0, 16'd0, 1'b0};
        hit = seg_count;
        if (addr == 0) begin
            g.status = hsa_pkg::ST_NULL;
            return g;
        end
        for (i = 0; i < seg_count; i++)
            if (((seg_off[i] + HEADER) & 16'hFFFF) == addr) begin
                hit = i;
                break;
            end
        if (hit == seg_count || seg_free[hit]) begin
            g.status = hsa_pkg::ST_BAD_FREE;
            return g;
        end
        seg_free[hit] = 1'b1;
        i = 0;
        while (i + 1 < seg_count) begin
            if (seg_free[i] && seg_free[i + 1]) begin
                seg_size[i] += seg_size[i + 1] + HEADER;
                drop_entry(i + 1);
            end else begin
                i++;
            end
        end
        return g;
    endfunction

    function void note_request(logic [0:0] kind, logic [15:0] bytes, logic [15:0] addr);
        if (kind == hsa_pkg::KIND_ALLOC) pending.push_back(allocate(bytes));
        else pending.push_back(release_segment(addr));
    endfunction

    function void check_response(t_grant got);
        t_grant want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected response status=%0d addr=%0d bytes=%0d reused=%0d",
                     $time, got.status, got.address, got.bytes, got.reused);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.address !== want.address) begin
            $display("%0t: granted_address expected %0d actual %0d",
                     $time, want.address, got.address);
            errors++;
        end
        if (got.bytes !== want.bytes) begin
            $display("%0t: granted_bytes expected %0d actual %0d",
                     $time, want.bytes, got.bytes);
            errors++;
        end
        if (got.reused !== want.reused) begin
            $display("%0t: reused expected %0d actual %0d", $time, want.reused, got.reused);
            errors++;
        end
    endfunction
endclass

module heap_segment_allocator_test;
    import hsa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;
    int         cycles;
    int         sender_idle;
    int         receiver_idle;
    heap_scoreboard board;

    hsa_req_if req_ch ();
    hsa_rsp_if rsp_ch ();

    heap_segment_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        board         = new();
        sender_idle   = 0;
        receiver_idle = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Responses are checked before the request of the same edge is noted,
    // since a response always belongs to an earlier transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_response('{rsp_ch.status, rsp_ch.granted_address,
                                       rsp_ch.granted_bytes, rsp_ch.reused});
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.kind, req_ch.request_bytes, req_ch.data_address);
        end
    end

    always @(negedge i_clk)
        rsp_ch.ready = ($urandom_range(99) >= receiver_idle);

    task automatic send_request(logic [0:0] kind, logic [15:0] bytes, logic [15:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.kind          = kind;
        req_ch.request_bytes = bytes;
        req_ch.data_address  = addr;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = p;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_policy(p);
    endtask

    task automatic random_request();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            send_request(KIND_ALLOC, 16'($urandom_range(1, 200)), 16'($urandom));
        else if (roll < 47)
            send_request(KIND_ALLOC, 16'($urandom_range(1000, 9000)), 16'($urandom));
        else if (roll < 82)
            send_request(KIND_FREE, 16'($urandom), board.used_address());
        else if (roll < 86)
            send_request(KIND_FREE, 16'($urandom), board.any_address());
        else if (roll < 90)
            send_request(KIND_FREE, 16'($urandom), 16'($urandom));
        else if (roll < 93)
            send_request(KIND_FREE, 16'($urandom), 16'd0);
        else if (roll < 96)
            send_request(KIND_ALLOC, 16'd0, 16'($urandom));
        else
            send_request(KIND_ALLOC, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [15:0] a;
        logic [15:0] b;
        cycles               = 0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = 2'd0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_ALLOC;
        req_ch.request_bytes = 16'd0;
        req_ch.data_address  = 16'd0;
        rsp_ch.ready         = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: edge sizes, null and bad frees, split, merge.
        write_policy(POL_FIRST);
        send_request(KIND_ALLOC, 16'd0, 16'd0);
        send_request(KIND_FREE, 16'd0, 16'd0);
        send_request(KIND_FREE, 16'hFFFF, 16'hFFFF);
        send_request(KIND_ALLOC, 16'hFFFF, 16'd0);
        send_request(KIND_ALLOC, 16'd1, 16'd0);
        send_request(KIND_ALLOC, 16'd4, 16'd0);
        send_request(KIND_ALLOC, 16'd5, 16'd0);
        send_request(KIND_ALLOC, 16'd300, 16'd0);
        send_request(KIND_ALLOC, 16'd100, 16'd0);
        drain();
        a = board.used_address();
        send_request(KIND_FREE, 16'd0, 16'd36 + 16'd32 + 16'd40);
        send_request(KIND_FREE, 16'd0, 16'd108 + 16'd32);
        send_request(KIND_FREE, 16'd0, 16'd108 + 16'd32);
        send_request(KIND_FREE, 16'd0, 16'd3);
        send_request(KIND_ALLOC, 16'd40, 16'd0);
        send_request(KIND_ALLOC, 16'd200, 16'd0);
        drain();
        b = board.used_address();
        send_request(KIND_FREE, 16'd0, b);
        send_request(KIND_FREE, 16'd0, a);
        drain();
        write_policy(POL_NEXT);
        send_request(KIND_ALLOC, 16'd8, 16'd0);
        send_request(KIND_ALLOC, 16'd8, 16'd0);
        send_request(KIND_ALLOC, 16'd65000, 16'd0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle = 24; receiver_idle = 80;
                end
                1: begin
                    sender_idle = 80; receiver_idle = 24;
                end
                default: begin
                    sender_idle = 0; receiver_idle = 0;
                end
            endcase
            write_policy(phase == 0 ? POL_BEST : phase == 1 ? POL_WORST :
                         phase == 2 ? POL_NEXT : POL_FIRST);
            for (int n = 0; n < 80; n++) random_request();
            drain();
            write_policy(2'($urandom_range(3)));
            for (int n = 0; n < 80; n++) random_request();
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
